/* rtl/core/slrm_pkg.sv */
// Shared types, codes and constants for the sorted line range matcher.
`default_nettype none

package slrm_pkg;

  // Table size default and fixed field widths
  localparam int unsigned RangeSlotsDefault = 64;
  localparam int unsigned ValueW            = 32;
  localparam int unsigned ActionW           = 2;
  localparam int unsigned CountW            = 6;

  // Action codes; the unused code is handled as a query
  localparam logic [ActionW-1:0] ActAdd    = 2'd0;
  localparam logic [ActionW-1:0] ActFinish = 2'd1;
  localparam logic [ActionW-1:0] ActQuery  = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_ZERO     = 3'd1,
    ST_FULL     = 3'd2,
    ST_FINISHED = 3'd3,
    ST_MATCH    = 3'd4,
    ST_NOMATCH  = 3'd5,
    ST_ENDED    = 3'd6
  } status_e;

  // Table read address select
  typedef enum logic [1:0] {
    RD_POS_M1 = 2'd0,
    RD_CUR    = 2'd1,
    RD_CUR_P1 = 2'd2
  } rd_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch;      // capture the input transfer
    logic    pos_load;   // insert position <= entry count
    logic    pos_dec;    // insert position - 1
    logic    rd_en;      // table read
    rd_sel_e rd_sel;
    logic    wr_new;     // write new range at insert position
    logic    wr_shift;   // move read entry up to insert position
    logic    cnt_inc;
    logic    cur_clear;
    logic    cur_inc;
    logic    act_set;    // cursor active <= table not empty
    logic    act_clear;
    logic    res_set;
    status_e res_code;
    logic    out_load;   // move result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_add;
    logic is_finish;
    logic zero_bound;
    logic full;
    logic pos_zero;
    logic cur_ok;       // cursor active and inside the table
    logic place_here;   // read entry orders at or before the new range
    logic end_below;    // read entry ends below the line
    logic start_above;  // read entry starts above the line
    logic cur_last;     // cursor is on the last entry
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/slrm_ctrl.sv */
// Controller state machine for the sorted line range matcher.
`default_nettype none

module slrm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire slrm_pkg::dp_sts_t sts_i,
  output slrm_pkg::dp_cmd_t     cmd_o
);
  import slrm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_ASTEP  = 7'b0000100,
    S_ACMP   = 7'b0001000,
    S_QCMP   = 7'b0010000,
    S_DONE   = 7'b0100000,
    S_SPARE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_add) begin
          cmd_o.act_clear = 1'b1;
          if (sts_i.zero_bound) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_ZERO;
            state_d        = S_DONE;
          end else if (sts_i.full) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_FULL;
            state_d        = S_DONE;
          end else begin
            cmd_o.pos_load = 1'b1;
            state_d        = S_ASTEP;
          end
        end else if (sts_i.is_finish) begin
          cmd_o.cur_clear = 1'b1;
          cmd_o.act_set   = 1'b1;
          cmd_o.res_set   = 1'b1;
          cmd_o.res_code  = ST_FINISHED;
          state_d         = S_DONE;
        end else if (!sts_i.cur_ok) begin
          cmd_o.act_clear = 1'b1;
          cmd_o.res_set   = 1'b1;
          cmd_o.res_code  = ST_ENDED;
          state_d         = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_CUR;
          state_d      = S_QCMP;
        end
      end
      // Walk down from the top: each entry is read in S_ASTEP and compared in S_ACMP
      S_ASTEP: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_new   = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_ADDED;
          state_d        = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_POS_M1;
          state_d      = S_ACMP;
        end
      end
      S_ACMP: begin
        if (sts_i.place_here) begin
          cmd_o.wr_new   = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_ADDED;
          state_d        = S_DONE;
        end else begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.pos_dec  = 1'b1;
          state_d        = S_ASTEP;
        end
      end
      // Cursor skips entries that end below the line
      S_QCMP: begin
        if (sts_i.end_below) begin
          cmd_o.cur_inc = 1'b1;
          if (sts_i.cur_last) begin
            cmd_o.act_clear = 1'b1;
            cmd_o.res_set   = 1'b1;
            cmd_o.res_code  = ST_ENDED;
            state_d         = S_DONE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_CUR_P1;
          end
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = sts_i.start_above ? ST_NOMATCH : ST_MATCH;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/slrm_dp.sv */
// Datapath of the sorted line range matcher: range table, cursor, count, result.
`default_nettype none

module slrm_dp #(
  parameter int unsigned RANGE_SLOTS = slrm_pkg::RangeSlotsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [slrm_pkg::ActionW-1:0]    action_i,
  input  wire logic [slrm_pkg::ValueW-1:0]     first_value_i,
  input  wire logic [slrm_pkg::ValueW-1:0]     second_value_i,
  input  wire slrm_pkg::dp_cmd_t               cmd_i,
  output slrm_pkg::dp_sts_t                    sts_o,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output slrm_pkg::status_e                    out_status_o,
  output logic [slrm_pkg::CountW-1:0]          out_count_o
);
  import slrm_pkg::*;

  localparam int unsigned IdxW = $clog2(RANGE_SLOTS);

  // Captured item: lo_q holds the line for queries
  logic [ActionW-1:0]  action_q;
  logic [ValueW-1:0]   lo_q, hi_q;
  logic [IdxW-1:0]     pos_q;
  logic [IdxW-1:0]     cnt_q, cur_q;
  logic                act_q;
  status_e             res_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [CountW-1:0]   out_count_q;

  // Range table, {end, start} per entry
  logic [2*ValueW-1:0] mem_q [RANGE_SLOTS];
  logic [2*ValueW-1:0] rd_q;
  logic [IdxW-1:0]     rd_addr;
  logic [ValueW-1:0]   rd_start, rd_end;
  logic [IdxW:0]       cur_nx;
  logic [IdxW+CountW-1:0] cnt_wide;
  logic                swap;

  assign rd_start = rd_q[ValueW-1:0];
  assign rd_end   = rd_q[2*ValueW-1:ValueW];
  assign swap     = (action_i == ActAdd) && (first_value_i > second_value_i);
  assign cur_nx   = {1'b0, cur_q} + (IdxW+1)'(1);
  assign cnt_wide = (IdxW+CountW)'(cnt_q);

  // Read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RD_POS_M1: rd_addr = pos_q - IdxW'(1);
      RD_CUR:    rd_addr = cur_q;
      RD_CUR_P1: rd_addr = cur_nx[IdxW-1:0];
      default:   rd_addr = cur_q;
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new) begin
      mem_q[pos_q] <= {hi_q, lo_q};
    end else if (cmd_i.wr_shift) begin
      mem_q[pos_q] <= rd_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      lo_q     <= swap ? second_value_i : first_value_i;
      hi_q     <= swap ? first_value_i : second_value_i;
    end
    if (cmd_i.pos_load) begin
      pos_q <= cnt_q;
    end else if (cmd_i.pos_dec) begin
      pos_q <= pos_q - IdxW'(1);
    end
    if (cmd_i.res_set) begin
      res_q <= cmd_i.res_code;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_q;
      out_count_q  <= cnt_wide[CountW-1:0];
    end
  end

  // Control state: count, cursor, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      if (cmd_i.cur_clear) begin
        cur_q <= '0;
      end else if (cmd_i.cur_inc) begin
        cur_q <= cur_nx[IdxW-1:0];
      end
      if (cmd_i.act_set) begin
        act_q <= (cnt_q != '0);
      end else if (cmd_i.act_clear) begin
        act_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o.is_add      = (action_q == ActAdd);
    sts_o.is_finish   = (action_q == ActFinish);
    sts_o.zero_bound  = (lo_q == '0);
    sts_o.full        = (cnt_q == IdxW'(RANGE_SLOTS - 1));
    sts_o.pos_zero    = (pos_q == '0);
    sts_o.cur_ok      = act_q && (cur_q < cnt_q);
    sts_o.place_here  = (rd_start < lo_q) || ((rd_start == lo_q) && (rd_end <= hi_q));
    sts_o.end_below   = (rd_end < lo_q);
    sts_o.start_above = (lo_q < rd_start);
    sts_o.cur_last    = (cur_nx >= {1'b0, cnt_q});
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

endmodule

`default_nettype wire

/* rtl/core/sorted_line_range_matcher_unit.sv */
// Per item: a finish, a rejected add or a query with no active cursor answers from decode;
//   a query reads the cursor entry and steps past each entry ending below the line, ending
//   if it runs off the table; an add walks down from the top, moving later entries up.
// Throughput: one item at a time; the next transfer is taken once the result sits in
//   the output register, which may still be waiting on m_axis_tready_i.
// Reset (rst_ni low, asynchronous): count, cursor and output valid clear; table undefined.
`default_nettype none

module sorted_line_range_matcher_unit #(
  parameter int unsigned RANGE_SLOTS = slrm_pkg::RangeSlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [31:0] first_value, [63:32] second_value
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [2:0] status, [8:3] range_count, rest zero
);
  import slrm_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  status_e           out_status;
  logic [CountW-1:0] out_count;

  // Sequencer
  slrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, cursor and output register
  slrm_dp #(
    .RANGE_SLOTS (RANGE_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (s_axis_tuser_i),
    .first_value_i  (s_axis_tdata_i[31:0]),
    .second_value_i (s_axis_tdata_i[63:32]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_status_o   (out_status),
    .out_count_o    (out_count)
  );

  assign m_axis_tdata_o = {7'b0, out_count, out_status};

endmodule

`default_nettype wire

/* rtl/core/slrm_checker.sv */
// Port-level checks for the sorted line range matcher, bound to the top level.
`default_nettype none

module slrm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [63:0] s_axis_tdata_i,
  input wire logic [1:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // One item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // A new result frees the input side at once
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("input not ready after result");

endmodule

bind sorted_line_range_matcher_unit slrm_checker u_slrm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

/* sim/sorted_line_range_matcher_unit_tb.sv */
// Testbench for the sorted line range matcher: stream stimulus, scoreboard and checks.
`timescale 1ns / 1ps

module sorted_line_range_matcher_unit_tb;
  import slrm_pkg::*;

  localparam int unsigned Slots       = RangeSlotsDefault;
  localparam int unsigned NumItems    = 1350;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned DrainLimit  = 100000;
  // longest add shifts every stored entry
  localparam int unsigned DrainCycles = 200;
  localparam longint unsigned TimeoutNs = 20_000_000;

  // spare action code, handled as a query
  localparam logic [ActionW-1:0] ActSpare = 2'd3;

  // receiver stall patterns
  localparam int unsigned RxOpen   = 0;
  localparam int unsigned RxRandom = 1;
  localparam int unsigned RxSparse = 2;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] count;
  } outcome_t;

  // Tracks the range table and cursor, predicts one outcome per transfer
  class line_range_scoreboard;
    logic [ValueW-1:0] range_lo[Slots];
    logic [ValueW-1:0] range_hi[Slots];
    int unsigned stored_cnt;
    int unsigned cur_idx;
    bit          cur_on;
    outcome_t    awaited[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned status_seen[8];

    function status_e insert_range(logic [ValueW-1:0] lo, logic [ValueW-1:0] hi);
      int unsigned pos;
      int unsigned k;
      logic [ValueW-1:0] t;
      cur_on = 1'b0;
      if (lo == '0 || hi == '0) return ST_ZERO;
      if (stored_cnt >= Slots - 1) return ST_FULL;
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      // new range goes after every entry ordered at or before it
      pos = stored_cnt;
      while (pos > 0) begin
        if (range_lo[pos-1] < lo || (range_lo[pos-1] == lo && range_hi[pos-1] <= hi)) break;
        pos--;
      end
      for (k = stored_cnt; k > pos; k--) begin
        range_lo[k] = range_lo[k-1];
        range_hi[k] = range_hi[k-1];
      end
      range_lo[pos] = lo;
      range_hi[pos] = hi;
      stored_cnt++;
      return ST_ADDED;
    endfunction

    function status_e match_line(logic [ValueW-1:0] line);
      if (!cur_on || cur_idx >= stored_cnt) begin
        cur_on = 1'b0;
        return ST_ENDED;
      end
      if (line < range_lo[cur_idx]) return ST_NOMATCH;
      if (line > range_hi[cur_idx]) begin
        // cursor only moves forward, past ranges ending below the line
        do begin
          cur_idx++;
          if (cur_idx >= stored_cnt) begin
            cur_on = 1'b0;
            return ST_ENDED;
          end
        end while (range_hi[cur_idx] < line);
        if (line < range_lo[cur_idx]) return ST_NOMATCH;
      end
      return ST_MATCH;
    endfunction

    function void note_item(logic [ActionW-1:0] act, logic [ValueW-1:0] a,
                            logic [ValueW-1:0] b);
      status_e st;
      outcome_t o;
      case (act)
        ActAdd: st = insert_range(a, b);
        ActFinish: begin
          cur_idx = 0;
          cur_on  = (stored_cnt > 0);
          st      = ST_FINISHED;
        end
        default: st = match_line(a);
      endcase
      o.status = st;
      o.count  = stored_cnt[CountW-1:0];
      awaited.push_back(o);
    endfunction

    function void check_result(logic [15:0] word);
      outcome_t o;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: result 0x%04h with nothing outstanding", $realtime, word);
        return;
      end
      o = awaited.pop_front();
      status_seen[o.status]++;
      if (word[2:0] !== o.status || word[8:3] !== o.count) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: result %0d: expected status %s count %0d, got status %0d count %0d",
                   $realtime, checked, o.status.name(), o.count, word[2:0], word[8:3]);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        $display("%0d expected results never arrived", awaited.size());
        errors += awaited.size();
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // [31:0] first_value, [63:32] second_value
  logic [1:0]  s_axis_tuser_i = '0;   // [1:0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // [2:0] status, [8:3] range_count

  line_range_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  sorted_line_range_matcher_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one item in bursts with random gaps; returns once the transfer happens
  task automatic send_item(input logic [ActionW-1:0] act, input logic [ValueW-1:0] a,
                           input logic [ValueW-1:0] b);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, a};
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(act, a, b);
    items_sent++;
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // Receiver: rotating stall patterns plus one long hold-off while input keeps coming
  initial begin
    int unsigned mode;
    int unsigned run_left;
    int unsigned hold_left;
    bit          hold_done;
    mode      = RxOpen;
    run_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && sb.checked >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(RxOpen, RxSparse);
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        case (mode)
          RxOpen:   m_axis_tready_i <= 1'b1;
          RxRandom: m_axis_tready_i <= 1'($urandom_range(0, 1));
          default:  m_axis_tready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Hard stop
  initial begin
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [ValueW-1:0] lo;
    logic [ValueW-1:0] hi;
    logic [ValueW-1:0] t;
    logic [ValueW-1:0] line;
    logic [ValueW-1:0] qline;
    int unsigned       kind;
    int unsigned       n_adds;
    int unsigned       n_queries;
    int unsigned       waited;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, zero bounds, reversed and tied ranges, cursor walk
    send_item(ActQuery, 32'd10, 32'd0);           // no finish yet
    send_item(ActFinish, 32'd0, 32'd0);           // finish on empty table
    send_item(ActQuery, 32'd10, 32'd0);           // cursor stays inactive
    send_item(ActAdd, 32'd0, 32'd5);
    send_item(ActAdd, 32'd5, 32'd0);
    send_item(ActAdd, 32'd0, 32'd0);
    send_item(ActAdd, 32'd200, 32'd100);          // reversed bounds
    send_item(ActAdd, 32'd100, 32'd150);          // same start, lower end
    send_item(ActAdd, 32'd100, 32'd200);          // duplicate
    send_item(ActAdd, 32'd1, 32'd1);
    send_item(ActQuery, 32'd1, 32'hFFFF_FFFF);    // add cleared the cursor
    send_item(ActFinish, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ActQuery, 32'd0, 32'd0);
    send_item(ActQuery, 32'd1, 32'd0);
    send_item(ActQuery, 32'd50, 32'd0);
    send_item(ActQuery, 32'd120, 32'd0);
    send_item(ActSpare, 32'd180, 32'd0);
    send_item(ActQuery, 32'd20, 32'd0);           // line goes backward
    send_item(ActQuery, 32'd5000, 32'd0);         // cursor runs off the table
    send_item(ActQuery, 32'd5000, 32'd0);
    send_item(ActAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(ActFinish, 32'd0, 32'd0);
    send_item(ActQuery, 32'hFFFF_FFFF, 32'd0);
    send_item(ActQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random: mostly load a few ranges, finish, then scan rising line numbers
    while (items_sent < NumItems) begin
      if ($urandom_range(0, 99) < 80) begin
        n_adds = $urandom_range(0, 4);
        repeat (n_adds) begin
          kind = $urandom_range(0, 15);
          lo   = $urandom_range(1, 2000);
          hi   = lo + $urandom_range(0, 60);
          if (kind == 0) lo = '0;
          else if (kind == 1) hi = '0;
          else if (kind == 2) begin
            lo = $urandom;
            hi = $urandom;
          end
          if ($urandom_range(0, 1)) begin
            t  = lo;
            lo = hi;
            hi = t;
          end
          send_item(ActAdd, lo, hi);
        end
        send_item(ActFinish, $urandom, $urandom);
        line      = $urandom_range(0, 100);
        n_queries = $urandom_range(4, 25);
        repeat (n_queries) begin
          kind = $urandom_range(0, 19);
          if (kind == 0) qline = $urandom;
          else if (kind == 1) qline = line - $urandom_range(1, 50);
          else qline = line;
          send_item((kind == 2) ? ActSpare : ActQuery, qline, $urandom);
          line = line + $urandom_range(0, 120);
        end
      end else begin
        // noise: any action, any values
        repeat ($urandom_range(1, 6))
          send_item(ActionW'($urandom_range(0, 3)), $urandom_range(0, 1) ? $urandom
                    : $urandom_range(0, 2100), $urandom);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    sb.close_out();

    $display("summary: %0d items (directed corners, random load and scan runs), %0d results, %0d ranges left",
             items_sent, sb.checked, sb.stored_cnt);
    $display("summary: added %0d, zero %0d, full %0d, finished %0d, match %0d, no match %0d, ended %0d",
             sb.status_seen[ST_ADDED], sb.status_seen[ST_ZERO], sb.status_seen[ST_FULL],
             sb.status_seen[ST_FINISHED], sb.status_seen[ST_MATCH],
             sb.status_seen[ST_NOMATCH], sb.status_seen[ST_ENDED]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
